// ----- rtl/weighted_sparse_count_filter_defines.svh -----
// Assertion macros shared by the checker of the weighted sparse count filter.
`ifndef WEIGHTED_SPARSE_COUNT_FILTER_DEFINES_SVH
`define WEIGHTED_SPARSE_COUNT_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WSCF_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("weighted_sparse_count_filter: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define WSCF_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("weighted_sparse_count_filter: next-cycle check failed");

`endif

// ----- rtl/wscf_pkg.sv -----
// Types, constants and helpers shared by the weighted sparse count filter.
package wscf_pkg;

  localparam int FEATURES_DEFAULT = 4096;
  localparam int FID_W            = 12;
  localparam int WORD_W           = 32;
  localparam int TOTAL_W          = 48;
  localparam int LIMIT_W          = 13;
  localparam int QUEUE_DEPTH      = 4;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;
  localparam int S_DATA_W         = 80;
  localparam int M_DATA_W         = 144;

  localparam logic [LIMIT_W-1:0] FEATURE_LIMIT_RESET = 13'd4096;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ENTRY = 1'b1
  } op_t;

  typedef enum logic {
    KIND_ENTRY  = 1'b0,
    KIND_TOTALS = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_INDEX  = 2'd1,
    ST_ZERO_TOTAL = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  typedef enum logic {
    REG_FEATURE_LIMIT = 1'b0,
    REG_WEIGHTED_MODE = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] feature_limit;
    logic               weighted_mode;
  } cfg_t;

  typedef struct packed {
    logic [FID_W-1:0]  fid;
    logic [WORD_W-1:0] count;
    logic [WORD_W-1:0] weight;
    logic              last;
    logic              bad;
    logic              wmode;
  } cmd_t;

  typedef struct packed {
    kind_t              kind;
    logic [FID_W-1:0]   fid;
    logic [WORD_W-1:0]  wcount;
    logic [TOTAL_W-1:0] raw;
    logic [TOTAL_W-1:0] eff;
    status_t            status;
    logic               last;
  } result_t;

  function automatic status_t raise_status(status_t cur, status_t code);
    return (code > cur) ? code : cur;
  endfunction

endpackage

// ----- rtl/wscf_regs.sv -----
// Configuration register file behind the APB-style port.
module wscf_regs
  import wscf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_index_t idx;
  logic       wr;

  assign idx    = reg_index_t'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.feature_limit <= FEATURE_LIMIT_RESET;
      cfg.weighted_mode <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_FEATURE_LIMIT: cfg.feature_limit <= pwdata[LIMIT_W-1:0];
        REG_WEIGHTED_MODE: cfg.weighted_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FEATURE_LIMIT: prdata = {{(CFG_DATA_W-LIMIT_W){1'b0}}, cfg.feature_limit};
      REG_WEIGHTED_MODE: prdata = {{(CFG_DATA_W-1){1'b0}}, cfg.weighted_mode};
      default:           prdata = '0;
    endcase
  end

endmodule

// ----- rtl/wscf_front.sv -----
// Front end: accepts requests, writes weight loads, classifies entries and reads weights.
module wscf_front
  import wscf_pkg::*;
#(
  parameter int FEATURES = FEATURES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [0:0]          s_tuser,
  input  logic                s_tlast,
  input  cfg_t                cfg,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output cmd_t                cmd
);

  localparam int AW = $clog2(FEATURES);

  logic [WORD_W-1:0] weight_mem [FEATURES];

  logic [FID_W-1:0]  fid;
  logic [WORD_W-1:0] weight;
  logic [WORD_W-1:0] count;
  logic [AW-1:0]     addr;
  logic              in_table;
  logic              bad;
  logic              accept;
  logic              is_entry;

  logic              valid;
  logic [FID_W-1:0]  fid_q;
  logic [WORD_W-1:0] count_q;
  logic [WORD_W-1:0] weight_q;
  logic              last_q;
  logic              bad_q;
  logic              wmode_q;

  assign fid      = s_tdata[11:0];
  assign weight   = s_tdata[43:12];
  assign count    = s_tdata[75:44];
  assign addr     = AW'(fid);
  assign in_table = int'(fid) < FEATURES;
  assign bad      = ({1'b0, fid} >= cfg.feature_limit) || !in_table;

  assign s_tready = !valid || cmd_ready;
  assign accept   = s_tvalid && s_tready;
  assign is_entry = s_tuser == OP_ENTRY;

  always_ff @(posedge clk) begin
    if (accept && !is_entry && in_table) begin
      weight_mem[addr] <= weight;
    end
    if (accept && is_entry && in_table) begin
      weight_q <= weight_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= accept && is_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_entry) begin
      fid_q   <= fid;
      count_q <= count;
      last_q  <= s_tlast;
      bad_q   <= bad;
      wmode_q <= cfg.weighted_mode;
    end
  end

  assign cmd_valid = valid;
  assign cmd = '{fid: fid_q, count: count_q, weight: weight_q, last: last_q,
                 bad: bad_q, wmode: wmode_q};

endmodule

// ----- rtl/wscf_queue.sv -----
// Short FIFO of classified entries between the front and back ends.
module wscf_queue
  import wscf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;
  logic          push;
  logic          pop;

  assign push_ready = fill != (PW+1)'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/wscf_back.sv -----
// Back end: weight multiply, saturating accumulation and result output with a spare slot.
module wscf_back
  import wscf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  cmd_t                cmd,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic [0:0]          m_tuser,
  output logic                m_tlast
);

  logic                    mv;
  cmd_t                    mcmd;
  logic [2*WORD_W-1:0]     prod;

  logic [TOTAL_W-1:0]      raw_acc;
  logic [TOTAL_W-1:0]      eff_acc;
  status_t                 status;

  logic                    out_valid;
  result_t                 out;
  logic                    pend_valid;
  result_t                 pend;

  logic                    take;
  logic                    m_advance;
  logic [WORD_W-1:0]       wval;
  logic                    povf;
  logic [WORD_W-1:0]       value;
  logic                    emit;
  logic [TOTAL_W:0]        raw_sum;
  logic [TOTAL_W:0]        eff_sum;
  logic [TOTAL_W-1:0]      raw_new;
  logic [TOTAL_W-1:0]      eff_new;
  status_t                 status_new;
  status_t                 status_fin;
  result_t                 entry_res;
  result_t                 tot_res;

  assign take      = mv && !pend_valid && (!out_valid || m_tready);
  assign m_advance = !mv || take;
  assign cmd_ready = m_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (m_advance) begin
      mv <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_advance && cmd_valid) begin
      mcmd <= cmd;
      prod <= (2*WORD_W)'(cmd.count) * (2*WORD_W)'(cmd.weight);
    end
  end

  always_comb begin
    povf       = |prod[63:48];
    wval       = povf ? '1 : prod[47:16];
    value      = mcmd.wmode ? wval : mcmd.count;
    emit       = !mcmd.bad && (!mcmd.wmode || (value != '0));
    raw_sum    = {1'b0, raw_acc} + (TOTAL_W+1)'(mcmd.count);
    eff_sum    = {1'b0, eff_acc} + (TOTAL_W+1)'(value);
    status_new = status;
    if (mcmd.bad) begin
      raw_new    = raw_acc;
      eff_new    = eff_acc;
      status_new = raise_status(status, ST_BAD_INDEX);
    end else begin
      raw_new = raw_sum[TOTAL_W] ? '1 : raw_sum[TOTAL_W-1:0];
      eff_new = eff_sum[TOTAL_W] ? '1 : eff_sum[TOTAL_W-1:0];
      if (raw_sum[TOTAL_W] || eff_sum[TOTAL_W] || (mcmd.wmode && povf)) begin
        status_new = raise_status(status, ST_OVERFLOW);
      end
    end
    status_fin = (eff_new == '0) ? raise_status(status_new, ST_ZERO_TOTAL) : status_new;

    entry_res = '{kind: KIND_ENTRY, fid: mcmd.fid, wcount: value, raw: '0, eff: '0,
                  status: ST_OK, last: !mcmd.last};
    tot_res   = '{kind: KIND_TOTALS, fid: '0, wcount: '0, raw: raw_new, eff: eff_new,
                  status: status_fin, last: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_acc    <= '0;
      eff_acc    <= '0;
      status     <= ST_OK;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (take) begin
      if (mcmd.last) begin
        raw_acc <= '0;
        eff_acc <= '0;
        status  <= ST_OK;
      end else begin
        raw_acc <= raw_new;
        eff_acc <= eff_new;
        status  <= status_new;
      end
      if (emit) begin
        out_valid  <= 1'b1;
        out        <= entry_res;
        pend_valid <= mcmd.last;
        pend       <= tot_res;
      end else if (mcmd.last) begin
        out_valid <= 1'b1;
        out       <= tot_res;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (out_valid && m_tready) begin
      out_valid  <= pend_valid;
      out        <= pend;
      pend_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out.status, out.eff, out.raw, out.wcount, out.fid};
  assign m_tuser  = out.kind;
  assign m_tlast  = out.last;

endmodule

// ----- rtl/weighted_sparse_count_filter.sv -----
// Top level of the weighted sparse count filter.
//
// Sustains one request per cycle on s_axis, loads and document entries alike, as long
// as m_axis takes results; a document entry that both passes and closes its document
// gives two results and holds the back end while the second waits in the spare slot.
// An entry is registered at the edge that accepts it, where the weight table is read,
// and then in the queue, the 32 by 32 bit weight multiply and the accumulate and output
// register. A weight load is visible to an entry accepted in the next cycle.
module weighted_sparse_count_filter
  import wscf_pkg::*;
#(
  parameter int FEATURES = FEATURES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // feature_id [11:0], weight_value [43:12], count_value [75:44], zero fill
  input  logic [S_DATA_W-1:0]   s_tdata,
  // operation
  input  logic [0:0]            s_tuser,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // entry_feature [11:0], weighted_count [43:12], raw_total [91:44],
  // effective_total [139:92], status [141:140], zero fill
  output logic [M_DATA_W-1:0]   m_tdata,
  // kind
  output logic [0:0]            m_tuser,
  output logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic back_valid;
  logic back_ready;
  cmd_t back_cmd;

  wscf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wscf_front #(
    .FEATURES (FEATURES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .cfg       (cfg),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  wscf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  wscf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ----- rtl/wscf_checker.sv -----
// Port-level checker for the weighted sparse count filter and its bind.
`include "weighted_sparse_count_filter_defines.svh"

module wscf_checker
  import wscf_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic [0:0]          m_tuser,
  input logic                m_tlast
);

  `WSCF_ASSERT_IMP(totals_close_request, clk, rst, m_tvalid && (m_tuser == KIND_TOTALS), m_tlast)
  `WSCF_ASSERT_IMP(totals_clear_entry_fields, clk, rst, m_tvalid && (m_tuser == KIND_TOTALS), m_tdata[43:0] == '0)
  `WSCF_ASSERT_IMP(entry_clear_total_fields, clk, rst, m_tvalid && (m_tuser == KIND_ENTRY), m_tdata[143:44] == '0)
  `WSCF_ASSERT_NXT(totals_follow_entry, clk, rst, m_tvalid && m_tready && (m_tuser == KIND_ENTRY) && !m_tlast, m_tvalid && (m_tuser == KIND_TOTALS))
  `WSCF_ASSERT_NXT(stalled_result_holds, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind weighted_sparse_count_filter wscf_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
